// ===== src/sttbl_pkg.sv =====
// Shared types, codes and constants for the soft timer table.
// Used by sttbl_cell, soft_timer_table_top and sttbl_checker; no dependencies.
`default_nettype none

package sttbl_pkg;

    localparam int SLOTS          = 15;
    localparam int TICK_PERIOD_MS = 10;
    localparam int MAX_FIRES      = 15;

    localparam int NOW_W    = 32;
    localparam int REQ_W    = 16;
    localparam int PERIOD_W = 17;
    localparam int CB_W     = 8;
    localparam int IDX_W    = 4;
    localparam int KIND_W   = 3;
    localparam int FIRE_W   = $clog2(MAX_FIRES + 1);

    // ceil(p / tick) by reciprocal multiply, exact for PERIOD_W-bit dividends
    localparam int  TICK_L    = $clog2(TICK_PERIOD_MS);
    localparam int  DIV_SHIFT = PERIOD_W + TICK_L;
    localparam int  MUL_W     = PERIOD_W + 1;
    localparam int  PROD_W    = PERIOD_W + MUL_W;
    localparam longint DIV_MUL =
        ((longint'(1) << DIV_SHIFT) + TICK_PERIOD_MS - 1) / TICK_PERIOD_MS;

    typedef enum logic [1:0] {
        OP_POLL = 2'd0,
        OP_REG  = 2'd1,
        OP_REM  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    localparam logic [1:0] MODE_FREE     = 2'd0;
    localparam logic [1:0] MODE_SINGLE   = 2'd1;
    localparam logic [1:0] MODE_PERIODIC = 2'd2;

    localparam logic [KIND_W-1:0] KIND_FIRED      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REGISTERED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_POLL_DONE  = 3'd5;

    typedef struct packed {
        op_t                 op;
        logic [NOW_W-1:0]    now;
        logic [PERIOD_W-1:0] period;
        logic [CB_W-1:0]     cb;
        logic                single;
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic              done;
        logic [FIRE_W-1:0] fires;
    } token_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
        logic [CB_W-1:0]   id;
        logic              last;
    } event_t;

    function automatic logic [PERIOD_W-1:0] tick_quot(input logic [REQ_W-1:0] p);
        logic [PERIOD_W-1:0] x;
        logic [PROD_W-1:0]   prod;
        x    = PERIOD_W'(p) + PERIOD_W'(TICK_PERIOD_MS - 1);
        prod = PROD_W'(x) * PROD_W'(DIV_MUL);
        return PERIOD_W'(prod >> DIV_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ===== src/soft_timer_table_top.sv =====
// Soft timer table top level: input register, chain of slot cells, output stage.
// Depends on sttbl_pkg and sttbl_cell.
//
// A table of SLOTS timer slots held in a chain of cells. Each accepted command
// (poll, register, remove) launches a token that walks the chain one cell per
// cycle while the output beat register is not held by m_axis_tready; every cell
// acts on its own slot as the token passes, so results come out in slot order.
// One command is in flight at a time: s_axis_tready returns once the token has
// passed the tail register, and later while m_axis_tready holds the output beat.
// The last beat of a command may still wait at the output while the next command
// is accepted. Opcode 3 is dropped with no result. Register rounds the period up
// to a whole number of ticks; a full table gives register_full.
`default_nettype none

module soft_timer_table_top
    import sttbl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // now[31:0], period[47:32],
                                             // callback_id[55:48], single_shot[56]
    input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // slot_index[3:0], fired_id[11:4]
    output logic [2:0]       m_axis_tuser,   // kind[2:0]
    output logic             m_axis_tlast
);

    logic                busy_reg, busy_next;
    token_t              head_reg, head_next;
    token_t              tail_reg;
    op_t                 op_reg;
    logic [NOW_W-1:0]    now_reg;
    logic [PERIOD_W-1:0] quot_reg;
    logic [CB_W-1:0]     cb_reg;
    logic                single_reg;
    logic                m_valid_reg;
    logic [KIND_W-1:0]   m_kind_reg;
    logic [IDX_W-1:0]    m_idx_reg;
    logic [CB_W-1:0]     m_id_reg;
    logic                m_last_reg;

    logic                     accept;
    logic                     adv;
    op_t                      in_op;
    cmd_t                     cmd;
    token_t                   chain [SLOTS+1];
    event_t                   cell_ev [SLOTS];
    logic [$bits(event_t)-1:0] ev_acc;
    event_t                   ev_all;
    event_t                   tail_ev;

    assign in_op         = op_t'(s_axis_tuser);
    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && !busy_reg;
    assign adv           = !m_valid_reg || m_axis_tready;

    assign cmd.op     = op_reg;
    assign cmd.now    = now_reg;
    assign cmd.period = PERIOD_W'(quot_reg * PERIOD_W'(TICK_PERIOD_MS));
    assign cmd.cb     = cb_reg;
    assign cmd.single = single_reg;

    assign chain[0] = head_reg;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        sttbl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (IDX_W'(g)),
            .adv     (adv),
            .cmd     (cmd),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1]),
            .ev      (cell_ev[g])
        );
    end

    // end of run: closing beat
    always_comb
    begin
        tail_ev = '0;
        if (tail_reg.valid)
        begin
            unique case (op_reg)
                OP_POLL: tail_ev = '{1'b1, KIND_POLL_DONE, '0, '0, 1'b1};
                OP_REG:
                begin
                    if (!tail_reg.done)
                        tail_ev = '{1'b1, KIND_FULL, '0, '0, 1'b1};
                end
                OP_REM:
                begin
                    if (!tail_reg.done)
                        tail_ev = '{1'b1, KIND_NOT_FOUND, '0, '0, 1'b1};
                end
                OP_NONE:
                begin
                end
            endcase
        end
    end

    // only the cell or tail stage holding the token drives a nonzero event
    always_comb
    begin
        ev_acc = tail_ev;
        for (int i = 0; i < SLOTS; i++)
            ev_acc = ev_acc | cell_ev[i];
        ev_all = event_t'(ev_acc);
    end

    always_comb
    begin
        busy_next = busy_reg;
        head_next = head_reg;
        if (adv)
            head_next = '0;
        if (tail_reg.valid && adv)
            busy_next = 1'b0;
        if (accept && (in_op != OP_NONE))
        begin
            busy_next = 1'b1;
            head_next = '{1'b1, 1'b0, '0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            head_reg <= head_next;
            if (adv)
            begin
                tail_reg    <= chain[SLOTS];
                m_valid_reg <= ev_all.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= in_op;
            now_reg    <= s_axis_tdata[31:0];
            quot_reg   <= tick_quot(s_axis_tdata[47:32]);
            cb_reg     <= s_axis_tdata[55:48];
            single_reg <= s_axis_tdata[56];
        end
        if (adv)
        begin
            m_kind_reg <= ev_all.kind;
            m_idx_reg  <= ev_all.idx;
            m_id_reg   <= ev_all.id;
            m_last_reg <= ev_all.last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, m_id_reg, m_idx_reg};
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== src/sttbl_cell.sv =====
// One timer slot of the chain: holds mode, period, start and callback id,
// acts on the token passing through it. Depends on sttbl_pkg.
`default_nettype none

module sttbl_cell
    import sttbl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic             adv,
    input  wire cmd_t             cmd,
    input  wire token_t           tok_in,
    output token_t                tok_out,
    output event_t                ev
);

    token_t              tok_reg;
    logic [1:0]          mode_reg, mode_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [NOW_W-1:0]    start_reg, start_next;
    logic [CB_W-1:0]     cb_reg, cb_next;
    logic                used;
    logic                due;
    logic [NOW_W-1:0]    elapsed;

    assign used    = (mode_reg != MODE_FREE);
    assign elapsed = cmd.now - start_reg;
    assign due     = used && (elapsed >= NOW_W'(period_reg));

    always_comb
    begin
        tok_out     = tok_reg;
        ev          = '0;
        mode_next   = mode_reg;
        period_next = period_reg;
        start_next  = start_reg;
        cb_next     = cb_reg;
        if (tok_reg.valid)
        begin
            unique case (cmd.op)
                OP_REG:
                begin
                    if (!tok_reg.done && !used)
                    begin
                        tok_out.done = 1'b1;
                        ev           = '{1'b1, KIND_REGISTERED, idx, cmd.cb, 1'b1};
                        if (adv)
                        begin
                            mode_next   = cmd.single ? MODE_SINGLE : MODE_PERIODIC;
                            period_next = cmd.period;
                            start_next  = cmd.now;
                            cb_next     = cmd.cb;
                        end
                    end
                end
                OP_REM:
                begin
                    if (!tok_reg.done && used && (cb_reg == cmd.cb))
                    begin
                        tok_out.done = 1'b1;
                        ev           = '{1'b1, KIND_REMOVED, idx, cmd.cb, 1'b1};
                        if (adv)
                            mode_next = MODE_FREE;
                    end
                end
                OP_POLL:
                begin
                    if (due)
                    begin
                        if (tok_reg.fires < FIRE_W'(MAX_FIRES))
                        begin
                            tok_out.fires = tok_reg.fires + 1'b1;
                            ev            = '{1'b1, KIND_FIRED, idx, cb_reg, 1'b0};
                        end
                        if (adv)
                        begin
                            if (mode_reg == MODE_SINGLE)
                                mode_next = MODE_FREE;
                            else
                                start_next = cmd.now;
                        end
                    end
                end
                OP_NONE:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= '0;
            mode_reg <= MODE_FREE;
        end
        else
        begin
            mode_reg <= mode_next;
            if (adv)
                tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg <= period_next;
        start_reg  <= start_next;
        cb_reg     <= cb_next;
    end

endmodule

`default_nettype wire

// ===== src/sttbl_checker.sv =====
// Port-level checks for soft_timer_table_top, attached by bind.
// Depends on sttbl_pkg.
`default_nettype none

module sttbl_checker
    import sttbl_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("output beat changed while stalled");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_NONE)) |=> !s_axis_tready)
        else $error("second command accepted while one is in flight");

    a_only_fire_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == KIND_FIRED))
        else $error("non-fired beat without tlast");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ((m_axis_tuser == KIND_FULL) || (m_axis_tuser == KIND_NOT_FOUND)
                           || (m_axis_tuser == KIND_POLL_DONE)))
            |-> (m_axis_tdata == 16'd0))
        else $error("status beat carries slot data");

endmodule

bind soft_timer_table_top sttbl_checker u_sttbl_checker (.*);

`default_nettype wire

// ===== test/tb_soft_timer_table_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for soft_timer_table_top: directed plan, then random poll/register/remove
// traffic with random stalls on both streams. Depends on sttbl_pkg and soft_timer_table_top.

module tb_soft_timer_table_top;
    import sttbl_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 95;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PLAN_ROWS    = 25;

    typedef struct packed {
        op_t              op;
        logic [NOW_W-1:0] now;
        logic [REQ_W-1:0] period;
        logic [CB_W-1:0]  cb;
        logic             single;
    } timer_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  slot;
        logic [CB_W-1:0]   id;
        logic              last;
    } timer_evt_t;

    typedef struct packed {
        timer_req_t req;
        logic       typed;
        timer_evt_t evt;
    } plan_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // table shadow
    logic [1:0]          tm_mode   [SLOTS];
    logic [PERIOD_W-1:0] tm_period [SLOTS];
    logic [NOW_W-1:0]    tm_start  [SLOTS];
    logic [CB_W-1:0]     tm_cb     [SLOTS];

    timer_evt_t step_events[$];
    timer_evt_t timer_events_due[$];

    int calm_left [2] = '{0, 0};
    int err_count     = 0;
    int beats_seen    = 0;
    int cycle_count   = 0;
    int polls_sent    = 0;
    int regs_sent     = 0;
    int removes_sent  = 0;
    int ignored_sent  = 0;
    int fires_due     = 0;
    int full_due      = 0;

    soft_timer_table_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    function automatic timer_req_t mk_req(input op_t op, input logic [NOW_W-1:0] now,
                                          input logic [REQ_W-1:0] period,
                                          input logic [CB_W-1:0] cb, input logic single);
        timer_req_t r;
        r.op     = op;
        r.now    = now;
        r.period = period;
        r.cb     = cb;
        r.single = single;
        return r;
    endfunction

    function automatic timer_evt_t mk_evt(input logic [KIND_W-1:0] kind,
                                          input logic [IDX_W-1:0] slot,
                                          input logic [CB_W-1:0] id, input logic last);
        timer_evt_t e;
        e.kind = kind;
        e.slot = slot;
        e.id   = id;
        e.last = last;
        return e;
    endfunction

    function automatic logic [PERIOD_W-1:0] ceil_to_tick(input logic [REQ_W-1:0] p);
        int unsigned q;
        q = ({16'd0, p} + TICK_PERIOD_MS - 1) / TICK_PERIOD_MS;
        return PERIOD_W'(q * TICK_PERIOD_MS);
    endfunction

    // 0: command side, 1: result side; occasional runs with no idling
    function automatic int draw_gap(input int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left[side] = $urandom_range(4, 20);
        return $urandom_range(0, 4);
    endfunction

    task automatic table_apply(input timer_req_t c);
        int               i;
        int               fires;
        logic [NOW_W-1:0] elapsed;
        bit               hit;
        step_events.delete();
        hit   = 1'b0;
        fires = 0;
        case (c.op)
            OP_REG:
            begin
                for (i = 0; i < SLOTS && !hit; i++)
                    if (tm_mode[i] == MODE_FREE)
                    begin
                        tm_mode[i]   = c.single ? MODE_SINGLE : MODE_PERIODIC;
                        tm_start[i]  = c.now;
                        tm_period[i] = ceil_to_tick(c.period);
                        tm_cb[i]     = c.cb;
                        step_events.push_back(mk_evt(KIND_REGISTERED, IDX_W'(i), c.cb, 1'b1));
                        hit = 1'b1;
                    end
                if (!hit)
                    step_events.push_back(mk_evt(KIND_FULL, '0, '0, 1'b1));
            end
            OP_REM:
            begin
                for (i = 0; i < SLOTS && !hit; i++)
                    if (tm_mode[i] != MODE_FREE && tm_cb[i] == c.cb)
                    begin
                        tm_mode[i] = MODE_FREE;
                        step_events.push_back(mk_evt(KIND_REMOVED, IDX_W'(i), c.cb, 1'b1));
                        hit = 1'b1;
                    end
                if (!hit)
                    step_events.push_back(mk_evt(KIND_NOT_FOUND, '0, '0, 1'b1));
            end
            OP_POLL:
            begin
                for (i = 0; i < SLOTS; i++)
                    if (tm_mode[i] != MODE_FREE)
                    begin
                        elapsed = c.now - tm_start[i];
                        if (elapsed >= NOW_W'(tm_period[i]))
                        begin
                            if (fires < MAX_FIRES)
                            begin
                                step_events.push_back(
                                    mk_evt(KIND_FIRED, IDX_W'(i), tm_cb[i], 1'b0));
                                fires++;
                            end
                            if (tm_mode[i] == MODE_SINGLE)
                                tm_mode[i] = MODE_FREE;
                            else
                                tm_start[i] = c.now;
                        end
                    end
                step_events.push_back(mk_evt(KIND_POLL_DONE, '0, '0, 1'b1));
            end
            default:
            begin
            end
        endcase
    endtask

    // Drives one command beat; valid stays high after the accept so back-to-back beats
    // never see valid lowered and raised in the same step.
    task automatic issue_request(input timer_req_t c, input logic typed,
                                 input timer_evt_t typed_evt);
        int gap;
        gap = draw_gap(0);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.op;
        s_axis_tdata  <= {7'd0, c.single, c.cb, c.period, c.now};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        table_apply(c);
        if (typed)
            timer_events_due.push_back(typed_evt);
        else
            foreach (step_events[k])
                timer_events_due.push_back(step_events[k]);
        foreach (step_events[k])
        begin
            if (step_events[k].kind == KIND_FIRED)
                fires_due++;
            if (step_events[k].kind == KIND_FULL)
                full_due++;
        end
        case (c.op)
            OP_POLL: polls_sent++;
            OP_REG:  regs_sent++;
            OP_REM:  removes_sent++;
            default: ignored_sent++;
        endcase
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        err_count++;
        $display("%0t beat %0d: %s got %0h, want %0h", $time, beats_seen, field, got, want);
    endtask

    initial
    begin : stimulus
        plan_row_t        plan [PLAN_ROWS];
        timer_req_t       req;
        logic [NOW_W-1:0] clock_ms;
        logic [CB_W-1:0]  live_cbs[$];
        int               roll;
        int               issued;
        int               i;

        for (i = 0; i < SLOTS; i++)
        begin
            tm_mode[i]   = MODE_FREE;
            tm_period[i] = '0;
            tm_start[i]  = '0;
            tm_cb[i]     = '0;
        end

        plan[0]  = '{mk_req(OP_POLL, 32'd0, 16'd0, 8'h00, 1'b0), 1'b1,
                     mk_evt(KIND_POLL_DONE, 4'd0, 8'h00, 1'b1)};
        plan[1]  = '{mk_req(OP_REM, 32'd0, 16'd0, 8'h55, 1'b0), 1'b1,
                     mk_evt(KIND_NOT_FOUND, 4'd0, 8'h00, 1'b1)};
        plan[2]  = '{mk_req(OP_REG, 32'd0, 16'd1, 8'h00, 1'b1), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd0, 8'h00, 1'b1)};
        plan[3]  = '{mk_req(OP_REG, 32'hFFFF_FFF0, 16'hFFFF, 8'hFF, 1'b0), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd1, 8'hFF, 1'b1)};
        plan[4]  = '{mk_req(OP_REG, 32'd1000, 16'd10, 8'hA5, 1'b0), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd2, 8'hA5, 1'b1)};
        plan[5]  = '{mk_req(OP_REG, 32'd1000, 16'd9, 8'h01, 1'b1), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd3, 8'h01, 1'b1)};
        plan[6]  = '{mk_req(OP_REG, 32'd1000, 16'd11, 8'h02, 1'b0), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd4, 8'h02, 1'b1)};
        plan[7]  = '{mk_req(OP_REG, 32'd1000, 16'd15, 8'hA5, 1'b0), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd5, 8'hA5, 1'b1)};
        plan[8]  = '{mk_req(OP_REG, 32'd1000, 16'd19, 8'h80, 1'b1), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd6, 8'h80, 1'b1)};
        plan[9]  = '{mk_req(OP_REG, 32'd1000, 16'd20, 8'h7F, 1'b0), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd7, 8'h7F, 1'b1)};
        plan[10] = '{mk_req(OP_REG, 32'd1000, 16'd1, 8'h5A, 1'b1), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd8, 8'h5A, 1'b1)};
        plan[11] = '{mk_req(OP_REG, 32'd1000, 16'h8000, 8'hC3, 1'b0), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd9, 8'hC3, 1'b1)};
        plan[12] = '{mk_req(OP_REG, 32'd1000, 16'hAAAA, 8'h3C, 1'b1), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd10, 8'h3C, 1'b1)};
        plan[13] = '{mk_req(OP_REG, 32'd1000, 16'h5555, 8'h10, 1'b0), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd11, 8'h10, 1'b1)};
        plan[14] = '{mk_req(OP_REG, 32'd1000, 16'd99, 8'h20, 1'b1), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd12, 8'h20, 1'b1)};
        plan[15] = '{mk_req(OP_REG, 32'd1000, 16'd101, 8'h40, 1'b0), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd13, 8'h40, 1'b1)};
        plan[16] = '{mk_req(OP_REG, 32'd1000, 16'hFFFE, 8'hFE, 1'b1), 1'b1,
                     mk_evt(KIND_REGISTERED, 4'd14, 8'hFE, 1'b1)};
        // table is full now
        plan[17] = '{mk_req(OP_REG, 32'd1000, 16'd50, 8'h33, 1'b0), 1'b1,
                     mk_evt(KIND_FULL, 4'd0, 8'h00, 1'b1)};
        plan[18] = '{mk_req(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1), 1'b0, '0};
        plan[19] = '{mk_req(OP_POLL, 32'd1005, 16'd0, 8'h00, 1'b0), 1'b0, '0};
        plan[20] = '{mk_req(OP_POLL, 32'd1020, 16'd0, 8'h00, 1'b0), 1'b0, '0};
        plan[21] = '{mk_req(OP_REM, 32'd1020, 16'd0, 8'hA5, 1'b0), 1'b0, '0};
        plan[22] = '{mk_req(OP_REM, 32'd1020, 16'd0, 8'hA5, 1'b0), 1'b0, '0};
        plan[23] = '{mk_req(OP_REG, 32'd1030, 16'd30, 8'h00, 1'b1), 1'b0, '0};
        plan[24] = '{mk_req(OP_POLL, 32'hFFFF_FFFF, 16'd0, 8'h00, 1'b0), 1'b0, '0};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < PLAN_ROWS; i++)
            issue_request(plan[i].req, plan[i].typed, plan[i].evt);

        // random traffic: mostly advancing time, now and then a jump anywhere
        clock_ms = 32'd2000;
        issued   = 0;
        while (issued < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 11) == 0)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, 40);
            req = mk_req(OP_POLL, clock_ms, REQ_W'($urandom), CB_W'($urandom),
                         1'($urandom_range(0, 1)));
            if (roll < 4)
            begin
                req.op  = OP_NONE;
                req.now = $urandom;
            end
            else if (roll < 42)
            begin
                req.op = OP_REG;
                if ($urandom_range(0, 3) == 0)
                    req.period = REQ_W'($urandom_range(1, 65535));
                else
                    req.period = REQ_W'($urandom_range(1, 300));
                // small id pool gives duplicates
                if ($urandom_range(0, 1) == 1)
                    req.cb = CB_W'($urandom_range(0, 7));
            end
            else if (roll < 64)
            begin
                req.op = OP_REM;
                live_cbs.delete();
                for (i = 0; i < SLOTS; i++)
                    if (tm_mode[i] != MODE_FREE)
                        live_cbs.push_back(tm_cb[i]);
                if (live_cbs.size() != 0 && $urandom_range(0, 3) != 0)
                    req.cb = live_cbs[$urandom_range(0, live_cbs.size() - 1)];
            end
            issue_request(req, 1'b0, '0);
            if (req.op != OP_NONE)
                issued++;
        end
        s_axis_tvalid <= 1'b0;

        while (timer_events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d polls, %0d registers, %0d removes, %0d unused-opcode beats",
                 polls_sent, regs_sent, removes_sent, ignored_sent);
        $display("checked %0d result beats: %0d firings, %0d table-full, %0d mismatches",
                 beats_seen, fires_due, full_due, err_count);
        if (err_count == 0)
            $display("tb_soft_timer_table_top: done, clean");
        else
            $display("tb_soft_timer_table_top: done, errors");
        $finish;
    end

    initial
    begin : result_sink
        int hold;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            hold = draw_gap(1);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : beat_check
        timer_evt_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_seen++;
            if (timer_events_due.size() == 0)
                report_mismatch("beat with nothing due, kind", m_axis_tuser, 0);
            else
            begin
                want = timer_events_due.pop_front();
                if (m_axis_tuser != want.kind)
                    report_mismatch("kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[3:0] != want.slot)
                    report_mismatch("slot_index", m_axis_tdata[3:0], want.slot);
                if (m_axis_tdata[11:4] != want.id)
                    report_mismatch("fired_id", m_axis_tdata[11:4], want.id);
                if (m_axis_tlast != want.last)
                    report_mismatch("tlast", m_axis_tlast, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, timer_events_due.size());
            $display("tb_soft_timer_table_top: done, errors");
            $finish;
        end
    end

endmodule

// ===== files.f =====
src/sttbl_pkg.sv
src/sttbl_cell.sv
src/soft_timer_table_top.sv
src/sttbl_checker.sv
test/tb_soft_timer_table_top.sv
